FILE: src/bcnp_pkg.sv
// shared constants and types for the binary choice n-gram predictor
`timescale 1ns / 1ps
`default_nettype none

package bcnp_pkg;

    localparam int HISTORY_LEN = 4;
    localparam int COUNT_BITS  = 16;

    localparam int IDX_W     = HISTORY_LEN;
    localparam int REC_W     = HISTORY_LEN - 1;
    localparam int PAT_DEPTH = 1 << HISTORY_LEN;

    localparam int WIDE_W = 16;
    localparam int TL_W   = 8;

    localparam logic [TL_W-1:0]       TRAINING_RESET = TL_W'(12);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX      = {COUNT_BITS{1'b1}};
    localparam logic [WIDE_W-1:0]     WIDE_MAX       = {WIDE_W{1'b1}};

    // controller to datapath
    typedef struct packed {
        logic issue;   // accept choice, launch the two count reads
        logic commit;  // update state, write count, load result register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_full;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: src/binary_choice_ngram_predictor_core.sv
// top level of the binary choice n-gram predictor
`timescale 1ns / 1ps
`default_nettype none

// Predicts each incoming one-bit choice from counts of the 4-bit patterns seen
// so far: the counts of {0, last three choices} and {1, last three choices}
// are compared and the larger wins, a tie predicting 1. Once more choices
// have been taken than training_length, each item is scored and hit_count
// grows on a correct prediction; trial_count reports choices seen minus
// training_length. All counters saturate at all ones. Each input transfer
// yields exactly one output transfer. An item has a read step, reading both
// pattern counts from the count table ram (registered read), and a commit
// step that compares, updates the counters and writes the incremented count
// back; no new choice is taken until the last item has committed. A result
// waiting in the output register does not block the next input transfer;
// the commit step of the following item waits until that result has been
// taken. training_length (reset 12) is written through the cfg channel,
// which is always ready, and should be written only while the block is idle.

module binary_choice_ngram_predictor_core
    import bcnp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration write channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [TL_W-1:0]   cfg_data,
    // input channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              choice,
    // output channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   prediction,
    output logic                   scored,
    output logic                   hit,
    output logic [WIDE_W-1:0]      hit_count,
    output logic [WIDE_W-1:0]      trial_count
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       cfg_we;

    // register write needs no wait
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // sequencing: issue reads on input transfer, commit when result slot frees
    bcnp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // count table, history, counters and result register
    bcnp_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .choice      (choice),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .prediction  (prediction),
        .scored      (scored),
        .hit         (hit),
        .hit_count   (hit_count),
        .trial_count (trial_count)
    );

endmodule

`default_nettype wire

FILE: src/bcnp_ram.sv
// generic ram, one write port, two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module bcnp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr_a,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output logic      [WIDTH-1:0]  rdata_a,
    output logic      [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

FILE: src/bcnp_ctrl.sv
// controller state machine for the predictor
`timescale 1ns / 1ps
`default_nettype none

module bcnp_ctrl
    import bcnp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       out_stall,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic slot_free;

    // result slot is free if empty or drained at this edge
    assign slot_free = !status.out_full || !out_stall;

    always_comb
    begin
        cmd.issue  = 1'b0;
        cmd.commit = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.issue  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/bcnp_datapath.sv
// datapath: pattern count table, counters, history and result register
`timescale 1ns / 1ps
`default_nettype none

module bcnp_datapath
    import bcnp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ctrl_cmd_t        cmd,
    output dp_status_t            status,
    input  wire logic             cfg_we,
    input  wire logic [TL_W-1:0]  cfg_data,
    input  wire logic             choice,
    input  wire logic             out_stall,
    output logic                  out_valid,
    output logic                  prediction,
    output logic                  scored,
    output logic                  hit,
    output logic [WIDE_W-1:0]     hit_count,
    output logic [WIDE_W-1:0]     trial_count
);

    logic [TL_W-1:0]       training_length_reg;
    logic [REC_W-1:0]      recent_reg;
    logic [REC_W-1:0]      recent_next;
    logic [WIDE_W-1:0]     seen_reg;
    logic [WIDE_W-1:0]     seen_next;
    logic [WIDE_W-1:0]     correct_reg;
    logic [WIDE_W-1:0]     correct_next;
    logic                  choice_reg;
    logic [PAT_DEPTH-1:0]  valid_reg;
    logic                  valid0_reg;
    logic                  valid1_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic [IDX_W-1:0]      idx0;
    logic [IDX_W-1:0]      idx1;
    logic [IDX_W-1:0]      widx;
    logic [COUNT_BITS-1:0] rd0;
    logic [COUNT_BITS-1:0] rd1;
    logic [COUNT_BITS-1:0] cnt0;
    logic [COUNT_BITS-1:0] cnt1;
    logic [COUNT_BITS-1:0] cnt_sel;
    logic [COUNT_BITS-1:0] cnt_wr;
    logic                  pred;
    logic                  is_scored;
    logic                  is_hit;
    logic [WIDE_W-1:0]     tl_wide;
    logic [WIDE_W-1:0]     trials;

    assign idx0 = {1'b0, recent_reg};
    assign idx1 = {1'b1, recent_reg};
    assign widx = {choice_reg, recent_reg};

    bcnp_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (PAT_DEPTH)
    ) u_counts (
        .clk     (clk),
        .we      (cmd.commit),
        .waddr   (widx),
        .wdata   (cnt_wr),
        .re      (cmd.issue),
        .raddr_a (idx0),
        .raddr_b (idx1),
        .rdata_a (rd0),
        .rdata_b (rd1)
    );

    // entries never written read as zero
    assign cnt0 = valid0_reg ? rd0 : '0;
    assign cnt1 = valid1_reg ? rd1 : '0;

    always_comb
    begin
        pred        = !(cnt0 > cnt1);
        seen_next   = (seen_reg != WIDE_MAX) ? seen_reg + WIDE_W'(1) : seen_reg;
        tl_wide     = WIDE_W'(training_length_reg);
        is_scored   = (seen_next > tl_wide);
        trials      = is_scored ? (seen_next - tl_wide) : '0;
        is_hit      = is_scored && (choice_reg == pred);
        correct_next = (is_hit && (correct_reg != WIDE_MAX))
                     ? correct_reg + WIDE_W'(1) : correct_reg;
        cnt_sel     = choice_reg ? cnt1 : cnt0;
        cnt_wr      = (cnt_sel != COUNT_MAX) ? cnt_sel + COUNT_BITS'(1) : cnt_sel;
        recent_next = (REC_W'(choice_reg) << (REC_W - 1)) | (recent_reg >> 1);
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            training_length_reg <= TRAINING_RESET;
            recent_reg          <= '0;
            seen_reg            <= '0;
            correct_reg         <= '0;
            valid_reg           <= '0;
            valid0_reg          <= 1'b0;
            valid1_reg          <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                training_length_reg <= cfg_data;
            end
            if (cmd.issue)
            begin
                valid0_reg <= valid_reg[idx0];
                valid1_reg <= valid_reg[idx1];
            end
            if (cmd.commit)
            begin
                recent_reg      <= recent_next;
                seen_reg        <= seen_next;
                correct_reg     <= correct_next;
                valid_reg[widx] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            choice_reg <= choice;
        end
        if (cmd.commit)
        begin
            prediction  <= pred;
            scored      <= is_scored;
            hit         <= is_hit;
            hit_count   <= correct_next;
            trial_count <= trials;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.out_full = out_valid_reg;

endmodule

`default_nettype wire

FILE: sim/tb.sv
// self-checking testbench for the binary choice n-gram predictor core
`timescale 1ns / 1ps

module tb;
    import bcnp_pkg::*;

    // one result transfer, in port order
    typedef struct packed {
        logic              prediction;
        logic              scored;
        logic              hit;
        logic [WIDE_W-1:0] hit_count;
        logic [WIDE_W-1:0] trial_count;
    } result_t;

    typedef enum logic {
        STEP_ITEM,
        STEP_CFG
    } step_kind_e;

    // directed row: a choice transfer or a training length write
    typedef struct packed {
        step_kind_e      kind;
        logic [TL_W-1:0] cfg_val;
        logic            ch;
        logic            typed;   // use the typed expectation below
        result_t         want;
    } step_t;

    localparam int DIR_N      = 23;
    localparam int ONES_ITEMS = 30;
    localparam int RAND_ITEMS = 180;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [TL_W-1:0]   cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic              choice;
    logic              out_valid;
    logic              out_stall;
    logic              prediction;
    logic              scored;
    logic              hit;
    logic [WIDE_W-1:0] hit_count;
    logic [WIDE_W-1:0] trial_count;

    // idle chance per cycle, in percent
    int unsigned src_idle;
    int unsigned snk_idle;
    int unsigned mismatch_count;

    // predictor state
    logic [COUNT_BITS-1:0] pat_cnt [PAT_DEPTH];
    logic [REC_W-1:0]      history;
    logic [WIDE_W-1:0]     seen;
    logic [WIDE_W-1:0]     correct;
    logic [TL_W-1:0]       train_len;

    result_t pending_results [$];
    step_t   dir_steps [DIR_N];

    binary_choice_ngram_predictor_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .choice      (choice),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .prediction  (prediction),
        .scored      (scored),
        .hit         (hit),
        .hit_count   (hit_count),
        .trial_count (trial_count)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // predict from the counts first, then score, then learn the pattern
    function automatic result_t predict_choice(input logic c);
        result_t        r;
        logic [IDX_W-1:0] lo_idx;
        logic [IDX_W-1:0] hi_idx;
        logic [IDX_W-1:0] upd_idx;
        r = '0;
        lo_idx = {1'b0, history};
        hi_idx = {1'b1, history};
        // a tie goes to 1
        r.prediction = !(pat_cnt[lo_idx] > pat_cnt[hi_idx]);
        if (seen != WIDE_MAX)
            seen = seen + 1'b1;
        if (seen > WIDE_W'(train_len))
        begin
            r.scored      = 1'b1;
            r.trial_count = seen - WIDE_W'(train_len);
            if (c == r.prediction)
            begin
                r.hit = 1'b1;
                if (correct != WIDE_MAX)
                    correct = correct + 1'b1;
            end
        end
        r.hit_count = correct;
        upd_idx = {c, history};
        if (pat_cnt[upd_idx] != COUNT_MAX)
            pat_cnt[upd_idx] = pat_cnt[upd_idx] + 1'b1;
        // newest choice enters at the top
        history = {c, history[REC_W-1:1]};
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [WIDE_W-1:0] want,
                                 input logic [WIDE_W-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    task automatic check_result();
        result_t want;
        result_t got;
        got = {prediction, scored, hit, hit_count, trial_count};
        if (pending_results.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: unexpected result transfer, expected none, actual %h",
                     $time, got);
        end
        else
        begin
            want = pending_results.pop_front();
            compare_field("prediction", want.prediction, got.prediction);
            compare_field("scored", want.scored, got.scored);
            compare_field("hit", want.hit, got.hit);
            compare_field("hit_count", want.hit_count, got.hit_count);
            compare_field("trial_count", want.trial_count, got.trial_count);
        end
    endtask

    // one choice transfer, with random gaps ahead of it
    task automatic send_choice(input logic c, input logic typed, input result_t want);
        result_t r;
        while ($urandom_range(99) < src_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        choice   <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = predict_choice(c);
        pending_results.push_back(typed ? want : r);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_training(input logic [TL_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        train_len = val;
    endtask

    // chunks of random bits or noisy repeating motifs, so the counts learn
    task automatic run_random(input int unsigned n);
        int unsigned sent;
        int unsigned chunk;
        int unsigned style;
        int unsigned period;
        int unsigned noise;
        int unsigned k;
        logic [7:0]  motif;
        logic        c;
        sent = 0;
        while (sent < n)
        begin
            chunk  = $urandom_range(10, 40);
            style  = $urandom_range(0, 3);
            motif  = 8'($urandom);
            period = $urandom_range(1, 8);
            noise  = $urandom_range(0, 15);
            for (k = 0; k < chunk && sent < n; k++)
            begin
                if (style == 0)
                    c = 1'($urandom_range(0, 1));
                else
                    c = motif[k % period] ^ ($urandom_range(99) < noise);
                send_choice(c, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // result side: random stall, check every accepted result
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                check_result();
            out_stall <= ($urandom_range(99) < snk_idle);
        end
    end

    initial
    begin
        int i;
        int ph;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        choice    <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        src_idle  = 7;
        snk_idle  = 64;
        mismatch_count = 0;
        for (i = 0; i < PAT_DEPTH; i++)
            pat_cnt[i] = '0;
        history   = '0;
        seen      = '0;
        correct   = '0;
        train_len = TRAINING_RESET;

        // first row after reset: empty counts tie, still in training
        dir_steps = '{
            '{STEP_ITEM, 8'd0,   1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 16'd0, 16'd0}},
            '{STEP_ITEM, 8'd0,   1'b1, 1'b0, '0},
            '{STEP_ITEM, 8'd0,   1'b1, 1'b0, '0},
            '{STEP_ITEM, 8'd0,   1'b0, 1'b0, '0},
            '{STEP_ITEM, 8'd0,   1'b1, 1'b0, '0},
            '{STEP_CFG,  8'd0,   1'b0, 1'b0, '0},
            '{STEP_ITEM, 8'd0,   1'b1, 1'b0, '0},
            '{STEP_ITEM, 8'd0,   1'b1, 1'b0, '0},
            '{STEP_ITEM, 8'd0,   1'b1, 1'b0, '0},
            '{STEP_ITEM, 8'd0,   1'b1, 1'b0, '0},
            '{STEP_ITEM, 8'd0,   1'b0, 1'b0, '0},
            '{STEP_ITEM, 8'd0,   1'b0, 1'b0, '0},
            '{STEP_CFG,  8'd255, 1'b0, 1'b0, '0},
            '{STEP_ITEM, 8'd0,   1'b0, 1'b0, '0},
            '{STEP_ITEM, 8'd0,   1'b1, 1'b0, '0},
            '{STEP_ITEM, 8'd0,   1'b0, 1'b0, '0},
            '{STEP_ITEM, 8'd0,   1'b1, 1'b0, '0},
            '{STEP_CFG,  8'd12,  1'b0, 1'b0, '0},
            '{STEP_ITEM, 8'd0,   1'b1, 1'b0, '0},
            '{STEP_ITEM, 8'd0,   1'b0, 1'b0, '0},
            '{STEP_ITEM, 8'd0,   1'b1, 1'b0, '0},
            '{STEP_ITEM, 8'd0,   1'b1, 1'b0, '0},
            '{STEP_ITEM, 8'd0,   1'b0, 1'b0, '0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_N; i++)
        begin
            if (dir_steps[i].kind == STEP_CFG)
            begin
                wait_drained();
                write_training(dir_steps[i].cfg_val);
            end
            else
                send_choice(dir_steps[i].ch, dir_steps[i].typed, dir_steps[i].want);
        end

        // random part in three idling phases, new training length each time
        for (ph = 0; ph < 3; ph++)
        begin
            wait_drained();
            src_idle = (ph == 0) ? 7 : (ph == 1) ? 64 : 0;
            snk_idle = (ph == 0) ? 64 : (ph == 1) ? 7 : 0;
            write_training((ph == 0) ? TL_W'($urandom_range(0, 40)) : TL_W'($urandom));
            run_random(RAND_ITEMS);
        end

        // run of ones pushes one pattern count well ahead of its partner
        wait_drained();
        write_training(8'd20);
        repeat (ONES_ITEMS) send_choice(1'b1, 1'b0, '0);

        // both training length extremes on a well trained table
        wait_drained();
        write_training(8'd255);
        run_random(12);
        wait_drained();
        write_training(8'd0);
        run_random(12);

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("binary_choice_ngram_predictor_core verification clean");
        else
            $display("binary_choice_ngram_predictor_core verification failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("binary_choice_ngram_predictor_core verification failed");
        $finish;
    end

endmodule

FILE: sim.f
src/bcnp_pkg.sv
src/bcnp_ram.sv
src/bcnp_ctrl.sv
src/bcnp_datapath.sv
src/binary_choice_ngram_predictor_core.sv
sim/tb.sv
